// ===== hw/rtl/kms_pkg.sv =====
// shared types and constants for the keypad matrix scanner
package kms_pkg;

    localparam int CODE_W      = 7;
    localparam int COL_W       = 3;
    localparam int LEVELS_W    = 8;
    localparam int OUT_SLOTS   = 6;
    localparam int HELD_W      = 3;
    localparam int CNT_W       = 8;
    localparam int COLS_CFG_W  = 4;
    localparam int ROWS_CFG_W  = 4;
    localparam int SPC_CFG_W   = 8;
    localparam int CAP_CFG_W   = 3;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    localparam logic [COLS_CFG_W-1:0] COLS_RESET = 4'd4;
    localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 4'd4;
    localparam logic [SPC_CFG_W-1:0]  SPC_RESET  = 8'd20;
    localparam logic [CAP_CFG_W-1:0]  CAP_RESET  = 3'd6;

    typedef enum logic [1:0] {
        REG_COLUMNS  = 2'd0,
        REG_ROWS     = 2'd1,
        REG_SAMPLES  = 2'd2,
        REG_CAPACITY = 2'd3
    } reg_idx_t;

endpackage

// ===== hw/rtl/keypad_matrix_scanner_rollover.sv =====
// keypad matrix scanner with ordered pressed-key list, apb configuration
// plain sample: S_IDLE takes the beat, S_DONE registers the result, then S_IDLE takes the next beat
// a column check visits each active row in S_ROW; a changed key with nonzero capacity adds a slot
// search in S_ADD or S_FIND, and a found release a shift in S_SHIFT (one slot a cycle; searches share one comparator)
// a held result stalls the scanner in S_DONE
// rst_n clears configuration to defaults, key map, list, column and counters
module keypad_matrix_scanner_rollover #(
    parameter int MAX_ROWS   = 8,
    parameter int MAX_COLS   = 8,
    parameter int LIST_SLOTS = 6
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [kms_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [kms_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [kms_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [kms_pkg::LEVELS_W-1:0]        row_levels,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [kms_pkg::COL_W-1:0]           drive_column,
    output logic [kms_pkg::CODE_W-1:0]          slot_0,
    output logic [kms_pkg::CODE_W-1:0]          slot_1,
    output logic [kms_pkg::CODE_W-1:0]          slot_2,
    output logic [kms_pkg::CODE_W-1:0]          slot_3,
    output logic [kms_pkg::CODE_W-1:0]          slot_4,
    output logic [kms_pkg::CODE_W-1:0]          slot_5,
    output logic [kms_pkg::HELD_W-1:0]          held_count
);

    localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int SW  = (LIST_SLOTS > 1) ? $clog2(LIST_SLOTS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW,
        S_ADD,
        S_FIND,
        S_SHIFT,
        S_DONE
    } state_t;

    state_t                                 state_reg, state_next;

    logic [kms_pkg::COLS_CFG_W-1:0]         cfg_cols_reg, cfg_cols_next;
    logic [kms_pkg::ROWS_CFG_W-1:0]         cfg_rows_reg, cfg_rows_next;
    logic [kms_pkg::SPC_CFG_W-1:0]          cfg_spc_reg, cfg_spc_next;
    logic [kms_pkg::CAP_CFG_W-1:0]          cfg_cap_reg, cfg_cap_next;

    logic [MAX_ROWS-1:0]                    map_reg [MAX_COLS];
    logic [MAX_ROWS-1:0]                    map_next [MAX_COLS];
    logic [kms_pkg::CODE_W-1:0]             slot_reg [LIST_SLOTS];
    logic [kms_pkg::CODE_W-1:0]             slot_next [LIST_SLOTS];

    logic [kms_pkg::COL_W-1:0]              col_reg, col_next;
    logic [kms_pkg::CNT_W-1:0]              cnt_reg, cnt_next;
    logic [kms_pkg::LEVELS_W-1:0]           seen_reg, seen_next;
    logic [MAX_ROWS-1:0]                    chk_seen_reg, chk_seen_next;
    logic [kms_pkg::COL_W-1:0]              chk_col_reg, chk_col_next;
    logic [RCW-1:0]                         row_reg, row_next;
    logic [SW-1:0]                          ptr_reg, ptr_next;
    logic [SW-1:0]                          fidx_reg, fidx_next;
    logic                                   found_reg, found_next;
    logic [kms_pkg::CODE_W-1:0]             code_reg, code_next;

    logic                                   out_valid_reg, out_valid_next;
    logic [kms_pkg::COL_W-1:0]              drive_reg, drive_next;
    logic [kms_pkg::CODE_W-1:0]             oslot_reg [kms_pkg::OUT_SLOTS];
    logic [kms_pkg::CODE_W-1:0]             oslot_next [kms_pkg::OUT_SLOTS];
    logic [kms_pkg::HELD_W-1:0]             held_reg, held_next;

    logic [kms_pkg::CODE_W-1:0]             slot_view [kms_pkg::OUT_SLOTS];
    logic [kms_pkg::CODE_W-1:0]             slot_up [LIST_SLOTS];

    logic [kms_pkg::SPC_CFG_W-1:0]          need;
    logic [kms_pkg::COLS_CFG_W-1:0]         cols_eff;
    logic [kms_pkg::ROWS_CFG_W-1:0]         rows_eff;
    logic [kms_pkg::CAP_CFG_W-1:0]          cap_eff;
    logic [kms_pkg::CNT_W-1:0]              cnt_inc;
    logic [kms_pkg::LEVELS_W-1:0]           seen_or;
    logic [kms_pkg::CAP_CFG_W-1:0]          ptr_ext;
    logic                                   ptr_last;
    logic [kms_pkg::CODE_W-1:0]             cmp_val;
    logic                                   cmp_hit;
    logic                                   key_now;
    logic                                   key_old;
    logic [kms_pkg::CODE_W-1:0]             row_code;
    logic [kms_pkg::HELD_W-1:0]             held_calc;
    logic                                   cfg_wr;

    // list view for outputs, and each slot's next-higher neighbour for removal
    for (genvar k = 0; k < kms_pkg::OUT_SLOTS; k++) begin : g_view
        if (k < LIST_SLOTS) begin : g_on
            assign slot_view[k] = slot_reg[k];
        end else begin : g_off
            assign slot_view[k] = '0;
        end
    end

    for (genvar k = 0; k < LIST_SLOTS; k++) begin : g_up
        if (k < LIST_SLOTS - 1) begin : g_on
            assign slot_up[k] = slot_reg[k + 1];
        end else begin : g_off
            assign slot_up[k] = '0;
        end
    end

    assign need     = (cfg_spc_reg == '0) ? 8'd1 : cfg_spc_reg;
    assign cols_eff = (cfg_cols_reg == '0) ? 4'd1 :
                      (cfg_cols_reg > 4'(MAX_COLS)) ? 4'(MAX_COLS) : cfg_cols_reg;
    assign rows_eff = (cfg_rows_reg > 4'(MAX_ROWS)) ? 4'(MAX_ROWS) : cfg_rows_reg;
    assign cap_eff  = (cfg_cap_reg > 3'(LIST_SLOTS)) ? 3'(LIST_SLOTS) : cfg_cap_reg;
    assign cnt_inc  = cnt_reg + 8'd1;
    assign seen_or  = seen_reg | row_levels;
    assign ptr_ext  = 3'(ptr_reg);
    assign ptr_last = (ptr_ext + 3'd1) >= cap_eff;

    // shared slot comparator: empty slot for insertion, key code for removal
    assign cmp_val  = (state_reg == S_ADD) ? '0 : code_reg;
    assign cmp_hit  = (slot_reg[ptr_reg] == cmp_val);

    assign key_now  = ~chk_seen_reg[row_reg[RW-1:0]];
    assign key_old  = map_reg[chk_col_reg[CW-1:0]][row_reg[RW-1:0]];
    assign row_code = kms_pkg::CODE_W'(int'(row_reg) * MAX_COLS + int'(chk_col_reg) + 1);

    assign cfg_wr   = psel && penable && pwrite;

    always_comb
    begin
        held_calc = '0;
        for (int i = 0; i < LIST_SLOTS; i++)
        begin
            held_calc = held_calc + kms_pkg::HELD_W'(slot_reg[i] != '0);
        end
    end

    always_comb
    begin
        unique case (kms_pkg::reg_idx_t'(paddr[3:2]))
            kms_pkg::REG_COLUMNS:  prdata = 32'(cfg_cols_reg);
            kms_pkg::REG_ROWS:     prdata = 32'(cfg_rows_reg);
            kms_pkg::REG_SAMPLES:  prdata = 32'(cfg_spc_reg);
            kms_pkg::REG_CAPACITY: prdata = 32'(cfg_cap_reg);
            default:               prdata = '0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cfg_cols_next  = cfg_cols_reg;
        cfg_rows_next  = cfg_rows_reg;
        cfg_spc_next   = cfg_spc_reg;
        cfg_cap_next   = cfg_cap_reg;
        map_next       = map_reg;
        slot_next      = slot_reg;
        col_next       = col_reg;
        cnt_next       = cnt_reg;
        seen_next      = seen_reg;
        chk_seen_next  = chk_seen_reg;
        chk_col_next   = chk_col_reg;
        row_next       = row_reg;
        ptr_next       = ptr_reg;
        fidx_next      = fidx_reg;
        found_next     = found_reg;
        code_next      = code_reg;
        out_valid_next = out_valid_reg;
        drive_next     = drive_reg;
        oslot_next     = oslot_reg;
        held_next      = held_reg;

        if (cfg_wr)
        begin
            unique case (kms_pkg::reg_idx_t'(paddr[3:2]))
                kms_pkg::REG_COLUMNS:  cfg_cols_next = pwdata[kms_pkg::COLS_CFG_W-1:0];
                kms_pkg::REG_ROWS:     cfg_rows_next = pwdata[kms_pkg::ROWS_CFG_W-1:0];
                kms_pkg::REG_SAMPLES:  cfg_spc_next  = pwdata[kms_pkg::SPC_CFG_W-1:0];
                kms_pkg::REG_CAPACITY: cfg_cap_next  = pwdata[kms_pkg::CAP_CFG_W-1:0];
                default:               cfg_cols_next = cfg_cols_reg;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (cnt_inc >= need)
                    begin
                        cnt_next      = '0;
                        seen_next     = '0;
                        chk_seen_next = seen_or[MAX_ROWS-1:0];
                        chk_col_next  = col_reg;
                        row_next      = '0;
                        if ((4'(col_reg) + 4'd1) >= cols_eff)
                        begin
                            col_next = '0;
                        end
                        else
                        begin
                            col_next = col_reg + 3'd1;
                        end
                        if (4'(col_reg) < 4'(MAX_COLS))
                        begin
                            state_next = S_ROW;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        cnt_next   = cnt_inc;
                        seen_next  = seen_or;
                        state_next = S_DONE;
                    end
                end
            end
            S_ROW:
            begin
                if (4'(row_reg) >= rows_eff)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                    if (key_now != key_old)
                    begin
                        map_next[chk_col_reg[CW-1:0]][row_reg[RW-1:0]] = key_now;
                        code_next  = row_code;
                        ptr_next   = '0;
                        found_next = 1'b0;
                        if (cap_eff != '0)
                        begin
                            state_next = key_now ? S_ADD : S_FIND;
                        end
                    end
                end
            end
            S_ADD:
            begin
                if (cmp_hit)
                begin
                    slot_next[ptr_reg] = code_reg;
                    state_next         = S_ROW;
                end
                else if (ptr_last)
                begin
                    state_next = S_ROW;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            S_FIND:
            begin
                // last matching slot wins
                if (cmp_hit)
                begin
                    found_next = 1'b1;
                    fidx_next  = ptr_reg;
                end
                if (ptr_last)
                begin
                    if (cmp_hit || found_reg)
                    begin
                        ptr_next   = cmp_hit ? ptr_reg : fidx_reg;
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        state_next = S_ROW;
                    end
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            S_SHIFT:
            begin
                if (ptr_last)
                begin
                    slot_next[ptr_reg] = '0;
                    state_next         = S_ROW;
                end
                else
                begin
                    slot_next[ptr_reg] = slot_up[ptr_reg];
                    ptr_next           = ptr_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    drive_next     = col_reg;
                    oslot_next     = slot_view;
                    held_next      = held_calc;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cfg_cols_reg  <= kms_pkg::COLS_RESET;
            cfg_rows_reg  <= kms_pkg::ROWS_RESET;
            cfg_spc_reg   <= kms_pkg::SPC_RESET;
            cfg_cap_reg   <= kms_pkg::CAP_RESET;
            for (int c = 0; c < MAX_COLS; c++)
            begin
                map_reg[c] <= '0;
            end
            for (int i = 0; i < LIST_SLOTS; i++)
            begin
                slot_reg[i] <= '0;
            end
            col_reg       <= '0;
            cnt_reg       <= '0;
            seen_reg      <= '0;
            chk_seen_reg  <= '0;
            chk_col_reg   <= '0;
            row_reg       <= '0;
            ptr_reg       <= '0;
            fidx_reg      <= '0;
            found_reg     <= 1'b0;
            code_reg      <= '0;
            out_valid_reg <= 1'b0;
            drive_reg     <= '0;
            for (int k = 0; k < kms_pkg::OUT_SLOTS; k++)
            begin
                oslot_reg[k] <= '0;
            end
            held_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cfg_cols_reg  <= cfg_cols_next;
            cfg_rows_reg  <= cfg_rows_next;
            cfg_spc_reg   <= cfg_spc_next;
            cfg_cap_reg   <= cfg_cap_next;
            map_reg       <= map_next;
            slot_reg      <= slot_next;
            col_reg       <= col_next;
            cnt_reg       <= cnt_next;
            seen_reg      <= seen_next;
            chk_seen_reg  <= chk_seen_next;
            chk_col_reg   <= chk_col_next;
            row_reg       <= row_next;
            ptr_reg       <= ptr_next;
            fidx_reg      <= fidx_next;
            found_reg     <= found_next;
            code_reg      <= code_next;
            out_valid_reg <= out_valid_next;
            drive_reg     <= drive_next;
            oslot_reg     <= oslot_next;
            held_reg      <= held_next;
        end
    end

    assign pready       = 1'b1;
    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign drive_column = drive_reg;
    assign slot_0       = oslot_reg[0];
    assign slot_1       = oslot_reg[1];
    assign slot_2       = oslot_reg[2];
    assign slot_3       = oslot_reg[3];
    assign slot_4       = oslot_reg[4];
    assign slot_5       = oslot_reg[5];
    assign held_count   = held_reg;

`ifndef SYNTH
    // one beat in flight at a time
    a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input beat taken while busy");

    // slot pointer stays inside the active list
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADD || state_reg == S_FIND || state_reg == S_SHIFT)
            |-> (3'(ptr_reg) < cap_eff))
        else $error("slot pointer beyond capacity");

    // shifting only follows a successful search
    a_shift_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> found_reg)
        else $error("list shift without a match");

    // held count never exceeds the list size
    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (held_count <= kms_pkg::HELD_W'(LIST_SLOTS)))
        else $error("held count out of range");
`endif

endmodule

// ===== sim/tb_keypad_matrix_scanner_rollover.sv =====
// testbench for the keypad matrix scanner: debounce, rollover list, column wrap, apb setup
module tb_keypad_matrix_scanner_rollover;

    localparam int KEY_ROWS    = 8;
    localparam int KEY_COLS    = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;

    typedef struct packed {
        logic [kms_pkg::COL_W-1:0]                           column;
        logic [kms_pkg::OUT_SLOTS-1:0][kms_pkg::CODE_W-1:0]  slots;
        logic [kms_pkg::HELD_W-1:0]                          held;
    } scan_result_t;

    logic                               clk = 1'b0;
    logic                               rst_n;
    logic                               psel;
    logic                               penable;
    logic                               pwrite;
    logic [kms_pkg::APB_ADDR_W-1:0]     paddr;
    logic [kms_pkg::APB_DATA_W-1:0]     pwdata;
    logic [kms_pkg::APB_DATA_W-1:0]     prdata;
    logic                               pready;
    logic                               in_valid;
    logic                               in_ready;
    logic [kms_pkg::LEVELS_W-1:0]       row_levels;
    logic                               out_valid;
    logic                               out_ready;
    logic [kms_pkg::COL_W-1:0]          drive_column;
    logic [kms_pkg::CODE_W-1:0]         slot_0;
    logic [kms_pkg::CODE_W-1:0]         slot_1;
    logic [kms_pkg::CODE_W-1:0]         slot_2;
    logic [kms_pkg::CODE_W-1:0]         slot_3;
    logic [kms_pkg::CODE_W-1:0]         slot_4;
    logic [kms_pkg::CODE_W-1:0]         slot_5;
    logic [kms_pkg::HELD_W-1:0]         held_count;

    // shadow of the block: configuration, key map, rollover list, scan position
    logic [kms_pkg::COLS_CFG_W-1:0]     cfg_cols;
    logic [kms_pkg::ROWS_CFG_W-1:0]     cfg_rows;
    logic [kms_pkg::SPC_CFG_W-1:0]      cfg_samples;
    logic [kms_pkg::CAP_CFG_W-1:0]      cfg_capacity;
    bit                                 key_down [KEY_ROWS*KEY_COLS];
    logic [kms_pkg::CODE_W-1:0]         roll_list [kms_pkg::OUT_SLOTS];
    logic [kms_pkg::COL_W-1:0]          scan_col;
    logic [kms_pkg::CNT_W-1:0]          sample_cnt;
    logic [kms_pkg::LEVELS_W-1:0]       high_seen;

    // keys held on the virtual matrix, one row mask per column
    logic [KEY_ROWS-1:0]                finger_rows [KEY_COLS];

    scan_result_t                       expected_scans [$];

    int  max_in_gap;
    int  max_out_stall;
    bit  hold_off_req;
    int  n_errors;
    int  n_samples;
    int  n_checks;
    int  n_writes;
    int  n_results;
    int  stall_cycles;

    keypad_matrix_scanner_rollover dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .row_levels   (row_levels),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .drive_column (drive_column),
        .slot_0       (slot_0),
        .slot_1       (slot_1),
        .slot_2       (slot_2),
        .slot_3       (slot_3),
        .slot_4       (slot_4),
        .slot_5       (slot_5),
        .held_count   (held_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int active_cols();
        if (cfg_cols == 0)
            return 1;
        return (cfg_cols > KEY_COLS) ? KEY_COLS : int'(cfg_cols);
    endfunction

    function automatic int active_rows();
        return (cfg_rows > KEY_ROWS) ? KEY_ROWS : int'(cfg_rows);
    endfunction

    function automatic int list_limit();
        return (cfg_capacity > kms_pkg::OUT_SLOTS) ? kms_pkg::OUT_SLOTS : int'(cfg_capacity);
    endfunction

    function automatic void list_insert(input logic [kms_pkg::CODE_W-1:0] code);
        int  lim;
        bit  placed;
        lim = list_limit();
        placed = 1'b0;
        for (int i = 0; i < lim; i++)
        begin
            if (!placed && roll_list[i] == '0)
            begin
                roll_list[i] = code;
                placed = 1'b1;
            end
        end
    endfunction

    function automatic void list_delete(input logic [kms_pkg::CODE_W-1:0] code);
        int lim;
        int hit;
        lim = list_limit();
        hit = -1;
        // last matching slot wins when a code sits twice
        for (int i = 0; i < lim; i++)
            if (roll_list[i] == code)
                hit = i;
        if (hit >= 0)
        begin
            for (int i = hit; i + 1 < lim; i++)
                roll_list[i] = roll_list[i + 1];
            roll_list[lim - 1] = '0;
        end
    endfunction

    function automatic void evaluate_column();
        int                          idx;
        bit                          now_down;
        logic [kms_pkg::CODE_W-1:0]  code;
        for (int r = 0; r < active_rows(); r++)
        begin
            now_down = !high_seen[r];
            idx = r * KEY_COLS + int'(scan_col);
            code = kms_pkg::CODE_W'(idx + 1);
            if (now_down != key_down[idx])
            begin
                if (now_down)
                    list_insert(code);
                else
                    list_delete(code);
                key_down[idx] = now_down;
            end
        end
        n_checks++;
    endfunction

    function automatic scan_result_t predict_scan(input logic [kms_pkg::LEVELS_W-1:0] lv);
        int            need;
        int            held;
        scan_result_t  res;
        need = (cfg_samples == 0) ? 1 : int'(cfg_samples);
        high_seen = high_seen | lv;
        sample_cnt = sample_cnt + 1'b1;
        if (sample_cnt >= need)
        begin
            evaluate_column();
            sample_cnt = '0;
            high_seen = '0;
            // also wraps a column left past the end by a lowered count
            if (int'(scan_col) + 1 >= active_cols())
                scan_col = '0;
            else
                scan_col = scan_col + 1'b1;
        end
        held = 0;
        res.column = scan_col;
        for (int k = 0; k < kms_pkg::OUT_SLOTS; k++)
        begin
            res.slots[k] = roll_list[k];
            if (roll_list[k] != '0)
                held++;
        end
        res.held = kms_pkg::HELD_W'(held);
        return res;
    endfunction

    function automatic logic [kms_pkg::LEVELS_W-1:0] scan_levels(input int noise_pct);
        logic [kms_pkg::LEVELS_W-1:0] lv;
        int                           roll;
        lv = ~finger_rows[scan_col];
        roll = $urandom_range(0, 99);
        if (roll < noise_pct)
            lv = lv | kms_pkg::LEVELS_W'($urandom);
        else if (roll < noise_pct + 4)
            lv = kms_pkg::LEVELS_W'($urandom);
        return lv;
    endfunction

    function automatic void move_fingers();
        int c;
        int r;
        int nr;
        nr = (active_rows() == 0) ? KEY_ROWS : active_rows();
        if ($urandom_range(0, 79) == 0)
        begin
            for (int i = 0; i < KEY_COLS; i++)
                finger_rows[i] = '0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            c = $urandom_range(0, active_cols() - 1);
            r = $urandom_range(0, nr - 1);
            finger_rows[c][r] = ~finger_rows[c][r];
        end
    endfunction

    task automatic apb_xfer(input logic wr, input kms_pkg::reg_idx_t idx,
                            input logic [kms_pkg::APB_DATA_W-1:0] wdata,
                            output logic [kms_pkg::APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        rdata = prdata;
    endtask

    task automatic reg_check(input kms_pkg::reg_idx_t idx,
                             input logic [kms_pkg::APB_DATA_W-1:0] want_val);
        logic [kms_pkg::APB_DATA_W-1:0] got_val;
        apb_xfer(1'b0, idx, '0, got_val);
        if (got_val !== want_val)
        begin
            $error("register %s expected %0d actual %0d", idx.name(), want_val, got_val);
            n_errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic cfg_write(input kms_pkg::reg_idx_t idx,
                             input logic [kms_pkg::APB_DATA_W-1:0] value);
        logic [kms_pkg::APB_DATA_W-1:0] mask;
        logic [kms_pkg::APB_DATA_W-1:0] unused;
        case (idx)
            kms_pkg::REG_COLUMNS:
            begin
                mask = (32'd1 << kms_pkg::COLS_CFG_W) - 1;
                cfg_cols = value[kms_pkg::COLS_CFG_W-1:0];
            end
            kms_pkg::REG_ROWS:
            begin
                mask = (32'd1 << kms_pkg::ROWS_CFG_W) - 1;
                cfg_rows = value[kms_pkg::ROWS_CFG_W-1:0];
            end
            kms_pkg::REG_SAMPLES:
            begin
                mask = (32'd1 << kms_pkg::SPC_CFG_W) - 1;
                cfg_samples = value[kms_pkg::SPC_CFG_W-1:0];
            end
            default:
            begin
                mask = (32'd1 << kms_pkg::CAP_CFG_W) - 1;
                cfg_capacity = value[kms_pkg::CAP_CFG_W-1:0];
            end
        endcase
        apb_xfer(1'b1, idx, value, unused);
        reg_check(idx, value & mask);
        n_writes++;
    endtask

    task automatic set_scan(input int cols, input int rows, input int samples, input int cap);
        cfg_write(kms_pkg::REG_COLUMNS, cols);
        cfg_write(kms_pkg::REG_ROWS, rows);
        cfg_write(kms_pkg::REG_SAMPLES, samples);
        cfg_write(kms_pkg::REG_CAPACITY, cap);
    endtask

    // one beat on the sample channel; valid stays up when no gap follows
    task automatic send_sample(input logic [kms_pkg::LEVELS_W-1:0] lv);
        int gap;
        gap = $urandom_range(0, max_in_gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        row_levels <= lv;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        expected_scans.push_back(predict_scan(lv));
        n_samples++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_scans.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic test_register_defaults();
        reg_check(kms_pkg::REG_COLUMNS, 32'(kms_pkg::COLS_RESET));
        reg_check(kms_pkg::REG_ROWS, 32'(kms_pkg::ROWS_RESET));
        reg_check(kms_pkg::REG_SAMPLES, 32'(kms_pkg::SPC_RESET));
        reg_check(kms_pkg::REG_CAPACITY, 32'(kms_pkg::CAP_RESET));
        send_sample(8'h00);
        send_sample(8'h00);
    endtask

    task automatic test_rollover_order();
        drain_results();
        set_scan(2, 8, 1, 6);
        // fill past capacity, release all, then press and release out of order
        send_sample(8'h00);
        send_sample(8'hFF);
        send_sample(8'hFF);
        send_sample(8'hFE);
        send_sample(8'h7F);
        send_sample(8'hFF);
        send_sample(8'hFF);
    endtask

    task automatic test_capacity_limits();
        drain_results();
        set_scan(1, 8, 1, 0);
        send_sample(8'h00);
        send_sample(8'hFF);
        drain_results();
        cfg_write(kms_pkg::REG_CAPACITY, 7);
        send_sample(8'h00);
        send_sample(8'hFF);
    endtask

    task automatic test_duplicate_codes();
        drain_results();
        set_scan(1, 2, 1, 6);
        send_sample(8'hFE);
        send_sample(8'hFC);
        drain_results();
        cfg_write(kms_pkg::REG_CAPACITY, 1);
        // release outside the searched slots leaves a stale code behind
        send_sample(8'hFD);
        send_sample(8'hFF);
        send_sample(8'hFD);
        drain_results();
        cfg_write(kms_pkg::REG_CAPACITY, 6);
        send_sample(8'hFF);
    endtask

    task automatic test_column_wrap();
        drain_results();
        set_scan(8, 15, 0, 6);
        repeat (6) send_sample(8'hFF);
        drain_results();
        cfg_write(kms_pkg::REG_COLUMNS, 3);
        cfg_write(kms_pkg::REG_ROWS, 0);
        send_sample(8'h00);
        drain_results();
        cfg_write(kms_pkg::REG_COLUMNS, 0);
        cfg_write(kms_pkg::REG_ROWS, 15);
        send_sample(8'h00);
        drain_results();
        cfg_write(kms_pkg::REG_COLUMNS, 15);
        send_sample(8'h00);
        send_sample(8'hFF);
    endtask

    task automatic test_slow_debounce();
        logic [kms_pkg::LEVELS_W-1:0] pressed;
        drain_results();
        set_scan(1, 8, 255, 6);
        for (int pass = 0; pass < 2; pass++)
        begin
            pressed = kms_pkg::LEVELS_W'($urandom);
            for (int i = 0; i < 255; i++)
            begin
                // one bounce on the lowest pressed row during the second window
                if (pass == 1 && i == 100)
                    send_sample(~pressed | (pressed & -pressed));
                else
                    send_sample(~pressed & kms_pkg::LEVELS_W'($urandom));
            end
        end
    endtask

    task automatic test_output_backpressure();
        drain_results();
        set_scan(4, 8, 1, 6);
        max_in_gap = 0;
        hold_off_req = 1'b1;
        repeat (80)
        begin
            move_fingers();
            send_sample(scan_levels(8));
        end
        drain_results();
        max_in_gap = 18;
    endtask

    task automatic test_random_scans(input int phases, input int per_phase);
        int r;
        int cols;
        int rows;
        int samples;
        int cap;
        for (int p = 0; p < phases; p++)
        begin
            drain_results();
            r = $urandom_range(0, 9);
            cols = (r == 0) ? 0 : (r == 1) ? $urandom_range(9, 15) : $urandom_range(1, 8);
            r = $urandom_range(0, 9);
            rows = (r == 0) ? 0 : (r == 1) ? $urandom_range(9, 15) : $urandom_range(1, 8);
            r = $urandom_range(0, 9);
            samples = (r < 6) ? $urandom_range(1, 3) : (r < 8) ? $urandom_range(4, 8) :
                      (r == 8) ? 0 : 20;
            cap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(2, 6);
            if (p == 0)
                set_scan(8, 8, 1, 6);
            else if (p == 1)
                set_scan(1, 1, 1, 1);
            else
                set_scan(cols, rows, samples, cap);
            case ($urandom_range(0, 3))
                0:
                begin
                    max_in_gap = 0;
                    max_out_stall = 0;
                end
                1:
                begin
                    max_in_gap = 0;
                    max_out_stall = 18;
                end
                2:
                begin
                    max_in_gap = 18;
                    max_out_stall = 0;
                end
                default:
                begin
                    max_in_gap = 18;
                    max_out_stall = 18;
                end
            endcase
            for (int i = 0; i < per_phase; i++)
            begin
                move_fingers();
                if ($urandom_range(0, 49) == 0)
                    drain_results();
                send_sample(scan_levels(12));
            end
        end
    endtask

    // result checker
    always @(posedge clk)
    begin : check_scan
        scan_result_t                want;
        logic [kms_pkg::CODE_W-1:0]  got_slot [kms_pkg::OUT_SLOTS];
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (expected_scans.size() == 0)
            begin
                $error("unexpected result beat");
                n_errors++;
            end
            else
            begin
                want = expected_scans.pop_front();
                n_results++;
                got_slot[0] = slot_0;
                got_slot[1] = slot_1;
                got_slot[2] = slot_2;
                got_slot[3] = slot_3;
                got_slot[4] = slot_4;
                got_slot[5] = slot_5;
                if (drive_column !== want.column)
                begin
                    $error("drive_column expected %0d actual %0d", want.column, drive_column);
                    n_errors++;
                end
                for (int k = 0; k < kms_pkg::OUT_SLOTS; k++)
                begin
                    if (got_slot[k] !== want.slots[k])
                    begin
                        $error("slot_%0d expected %0d actual %0d", k, want.slots[k], got_slot[k]);
                        n_errors++;
                    end
                end
                if (held_count !== want.held)
                begin
                    $error("held_count expected %0d actual %0d", want.held, held_count);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles = 0;
        else
            stall_cycles = stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off on request
    initial
    begin : result_sink
        int n;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                n = HOLD_CYCLES;
            end
            else
                n = $urandom_range(0, max_out_stall);
            if (n > 0)
            begin
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
        end
    end

    initial
    begin
        cfg_cols     = kms_pkg::COLS_RESET;
        cfg_rows     = kms_pkg::ROWS_RESET;
        cfg_samples  = kms_pkg::SPC_RESET;
        cfg_capacity = kms_pkg::CAP_RESET;
        for (int i = 0; i < KEY_ROWS * KEY_COLS; i++)
            key_down[i] = 1'b0;
        for (int i = 0; i < kms_pkg::OUT_SLOTS; i++)
            roll_list[i] = '0;
        for (int i = 0; i < KEY_COLS; i++)
            finger_rows[i] = '0;
        scan_col      = '0;
        sample_cnt    = '0;
        high_seen     = '0;
        max_in_gap    = 18;
        max_out_stall = 18;
        hold_off_req  = 1'b0;
        n_errors      = 0;
        n_samples     = 0;
        n_checks      = 0;
        n_writes      = 0;
        n_results     = 0;
        stall_cycles  = 0;
        rst_n      <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        in_valid   <= 1'b0;
        row_levels <= '1;
        out_ready  <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_defaults();
        test_rollover_order();
        test_capacity_limits();
        test_duplicate_codes();
        test_column_wrap();
        test_slow_debounce();
        test_output_backpressure();
        test_random_scans(7, 100);

        drain_results();
        repeat (120) @(posedge clk);
        $display("%0d row samples, %0d column checks, %0d register writes, %0d results compared",
                 n_samples, n_checks, n_writes, n_results);
        $display("covered rollover order, full and zero capacity, stale codes, column wrap, stalls");
        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
